FILE: rtl/uppr_pkg.sv
// shared types and constants of the udp port packet reflector
package uppr_pkg;

  localparam int HDR_WORDS = 10;
  localparam int HDR_IDX_W = $clog2(HDR_WORDS);
  localparam int POS_W     = 4;

  localparam int DATA_W    = 64;
  localparam int BYTES_W   = 4;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [15:0]        DEFAULT_PORT = 16'd4790;
  localparam logic [15:0]        ETYPE_IPV4   = 16'h0800;
  localparam logic [7:0]         PROTO_UDP    = 8'd17;
  localparam logic [3:0]         MIN_IHL      = 4'd5;
  localparam logic [BYTES_W-1:0] BYTES_FULL   = 4'd8;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_REFLECT_PORT   = 1'b0,
    REG_REFLECT_ENABLE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] port;
    logic        enable;
  } cfg_t;

endpackage

FILE: rtl/uppr_apb_regs.sv
// apb configuration registers of the reflector
module uppr_apb_regs
  import uppr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.port   <= DEFAULT_PORT;
      cfg.enable <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        REG_REFLECT_PORT:   cfg.port   <= pwdata[15:0];
        REG_REFLECT_ENABLE: cfg.enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_REFLECT_PORT:   prdata = {16'd0, cfg.port};
      REG_REFLECT_ENABLE: prdata = {31'd0, cfg.enable};
      default:            prdata = '0;
    endcase
  end

endmodule

FILE: rtl/udp_port_packet_reflector.sv
// top level of the udp port packet reflector
//
// Takes an Ethernet frame as 64-bit words (first byte in the top byte) and
// reflects IPv4/UDP frames whose destination port equals reflect_port while
// reflect_enable is set: MACs, IP addresses and UDP ports are swapped and the
// frame is sent back out; any other frame is dropped whole, as is one with
// IHL below 5 or one that ends before its UDP destination port. The leading
// header words (5 words for IHL 5 up to 10 for IHL 15) are held in a register
// buffer, one word taken per cycle unless stalled. Once the word holding the
// destination port arrives the decision is made, and a match emits the
// buffered words one per cycle while the skid stage is empty, with the swaps
// patched in at read-out; input is stalled meanwhile. The frame's remainder
// streams through the output register at one item per cycle unless stalled.
// The output register is backed by a one-word skid stage, so in_stall depends
// only on registers. Configuration goes through an APB port: reflect_port at
// 0x0 (reset 4790), reflect_enable at 0x4 (reset 1).
module udp_port_packet_reflector
  import uppr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DATA_W-1:0]  in_data,
  input  logic [BYTES_W-1:0] in_bytes,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  out_data,
  output logic [BYTES_W-1:0] out_bytes,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    MODE_COLLECT,
    MODE_PASS,
    MODE_DROP
  } mode_t;

  cfg_t cfg;

  uppr_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // frame tracking
  mode_t            mode, mode_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [3:0]       hlw, hlw_next;          // header length in words, 0 = unknown
  logic             ihl_odd, ihl_odd_next;
  logic [15:0]      prev_lo, prev_lo_next;  // last two bytes of previous word
  logic [15:0]      udp_src, udp_src_next;
  logic [15:0]      udp_dst, udp_dst_next;

  // header buffer, one register per word
  logic [DATA_W-1:0] hdr [HDR_WORDS];
  logic              hdr_wr;

  // burst read-out of the header
  logic                 emit_busy, emit_busy_next;
  logic [HDR_IDX_W-1:0] emit_idx, emit_idx_next;
  logic [3:0]           emit_len, emit_len_next;
  logic [BYTES_W-1:0]   fin_bytes, fin_bytes_next;
  logic                 fin_last, fin_last_next;
  logic                 emit_fin;

  // output register and skid stage
  logic               skid_valid;
  logic [DATA_W-1:0]  skid_data;
  logic [BYTES_W-1:0] skid_bytes;
  logic               skid_last;

  // word produced this cycle
  logic               prod;
  logic [DATA_W-1:0]  prod_data;
  logic [BYTES_W-1:0] prod_bytes;
  logic               prod_last;

  logic               in_acc;
  logic [BYTES_W-1:0] nb;
  logic [POS_W-1:0]   pos_inc;
  logic [15:0]        etype;
  logic [3:0]         ihl;
  logic [6:0]         hlw_calc;
  logic [15:0]        dport;
  logic               too_short;
  logic               match;

  logic [DATA_W-1:0]  patch [HDR_WORDS];
  logic [DATA_W-1:0]  emit_word;

  assign in_stall = emit_busy || skid_valid;
  assign in_acc   = in_valid && !in_stall;
  assign nb       = (in_bytes == '0 || in_bytes > BYTES_FULL) ? BYTES_FULL : in_bytes;
  assign pos_inc  = pos + POS_W'(1);

  // word 1: ethertype in bytes 4..5, ihl in low nibble of byte 6
  assign etype    = in_data[31:16];
  assign ihl      = in_data[11:8];
  assign hlw_calc = ((7'd17 + {1'b0, ihl, 2'b00}) >> 3) + 7'd1;

  // destination port sits in the header's final word: bytes 4..5 for odd ihl,
  // bytes 0..1 for even ihl (then the source port ends the previous word)
  assign dport     = ihl_odd ? in_data[31:16] : in_data[63:48];
  assign too_short = in_last && (ihl_odd ? (nb <= BYTES_W'(5)) : (nb <= BYTES_W'(1)));
  assign match     = cfg.enable && (hdr[2][7:0] == PROTO_UDP) && (dport == cfg.port);

  assign emit_fin = (4'(emit_idx) == emit_len - 4'd1);

  // mac and ip swaps are fixed byte moves between fixed words
  always_comb begin
    for (int i = 0; i < HDR_WORDS; i++) begin
      patch[i] = hdr[i];
    end
    patch[0] = {hdr[0][15:0], hdr[1][63:32], hdr[0][63:48]};
    patch[1] = {hdr[0][47:16], hdr[1][31:0]};
    patch[3] = {hdr[3][63:48], hdr[3][15:0], hdr[4][63:48], hdr[3][47:32]};
    patch[4] = {hdr[3][31:16], hdr[4][47:0]};
  end

  // udp port swap lands in the last one or two header words
  always_comb begin
    emit_word = patch[emit_idx];
    if (emit_fin) begin
      if (ihl_odd) begin
        emit_word[47:32] = udp_dst;
        emit_word[31:16] = udp_src;
      end else begin
        emit_word[63:48] = udp_src;
      end
    end else if (!ihl_odd && (4'(emit_idx) == emit_len - 4'd2)) begin
      emit_word[15:0] = udp_dst;
    end
  end

  always_comb begin
    mode_next      = mode;
    pos_next       = pos;
    hlw_next       = hlw;
    ihl_odd_next   = ihl_odd;
    prev_lo_next   = prev_lo;
    udp_src_next   = udp_src;
    udp_dst_next   = udp_dst;
    emit_busy_next = emit_busy;
    emit_idx_next  = emit_idx;
    emit_len_next  = emit_len;
    fin_bytes_next = fin_bytes;
    fin_last_next  = fin_last;
    hdr_wr         = 1'b0;
    prod           = 1'b0;
    prod_data      = in_data;
    prod_bytes     = nb;
    prod_last      = in_last;

    if (in_acc) begin
      unique case (mode)
        MODE_PASS: begin
          prod = 1'b1;
          if (in_last) begin
            mode_next = MODE_COLLECT;
            pos_next  = '0;
            hlw_next  = '0;
          end
        end
        MODE_DROP: begin
          if (in_last) begin
            mode_next = MODE_COLLECT;
            pos_next  = '0;
            hlw_next  = '0;
          end
        end
        MODE_COLLECT: begin
          hdr_wr       = (pos < POS_W'(HDR_WORDS));
          pos_next     = pos_inc;
          prev_lo_next = in_data[15:0];
          if (pos == POS_W'(1)) begin
            if (etype != ETYPE_IPV4 || ihl < MIN_IHL) begin
              mode_next = in_last ? MODE_COLLECT : MODE_DROP;
            end else begin
              hlw_next     = hlw_calc[3:0];
              ihl_odd_next = ihl[0];
            end
            if (in_last) begin
              pos_next = '0;
              hlw_next = '0;
            end
          end else if (hlw != '0 && pos_inc >= hlw) begin
            // header complete
            if (too_short) begin
              pos_next = '0;
              hlw_next = '0;
            end else if (!match) begin
              mode_next = in_last ? MODE_COLLECT : MODE_DROP;
              if (in_last) begin
                pos_next = '0;
                hlw_next = '0;
              end
            end else begin
              emit_busy_next = 1'b1;
              emit_idx_next  = '0;
              emit_len_next  = hlw;
              fin_bytes_next = nb;
              fin_last_next  = in_last;
              udp_src_next   = ihl_odd ? in_data[47:32] : prev_lo;
              udp_dst_next   = dport;
              mode_next      = in_last ? MODE_COLLECT : MODE_PASS;
              if (in_last) begin
                pos_next = '0;
                hlw_next = '0;
              end
            end
          end else if (in_last) begin
            pos_next = '0;
            hlw_next = '0;
          end
        end
        default: ;
      endcase
    end else if (emit_busy && !skid_valid) begin
      prod       = 1'b1;
      prod_data  = emit_word;
      prod_bytes = emit_fin ? fin_bytes : BYTES_FULL;
      prod_last  = emit_fin && fin_last;
      if (emit_fin) begin
        emit_busy_next = 1'b0;
      end else begin
        emit_idx_next = emit_idx + HDR_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_COLLECT;
      pos        <= '0;
      hlw        <= '0;
      emit_busy  <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      mode      <= mode_next;
      pos       <= pos_next;
      hlw       <= hlw_next;
      emit_busy <= emit_busy_next;
      if (out_valid && out_stall) begin
        if (prod) begin
          skid_valid <= 1'b1;
          skid_data  <= prod_data;
          skid_bytes <= prod_bytes;
          skid_last  <= prod_last;
        end
      end else if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        out_bytes  <= skid_bytes;
        out_last   <= skid_last;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= prod;
        out_data  <= prod_data;
        out_bytes <= prod_bytes;
        out_last  <= prod_last;
      end
    end
    ihl_odd   <= ihl_odd_next;
    prev_lo   <= prev_lo_next;
    udp_src   <= udp_src_next;
    udp_dst   <= udp_dst_next;
    emit_idx  <= emit_idx_next;
    emit_len  <= emit_len_next;
    fin_bytes <= fin_bytes_next;
    fin_last  <= fin_last_next;
    if (hdr_wr) begin
      hdr[pos[HDR_IDX_W-1:0]] <= in_data;
    end
  end

endmodule

FILE: rtl/uppr_checker.sv
// port-level checks of the reflector, bound to the top level
module uppr_checker
  import uppr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [DATA_W-1:0]  in_data,
  input logic [BYTES_W-1:0] in_bytes,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DATA_W-1:0]  out_data,
  input logic [BYTES_W-1:0] out_bytes,
  input logic               out_last,
  input logic               psel,
  input logic               penable,
  input logic               pready
);

  // reset leaves no item pending and the input open
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(out_data) && $stable(out_bytes) && $stable(out_last))
    else $error("stalled output item changed");

  // a stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=>
      in_valid && $stable(in_data) && $stable(in_bytes) && $stable(in_last))
    else $error("stalled input item changed");

  // every emitted word carries one to eight bytes
  a_out_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_bytes >= BYTES_W'(1) && out_bytes <= BYTES_FULL)
    else $error("output byte count out of range");

  // register port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst)
    psel && penable |-> pready)
    else $error("pready low during access");

endmodule

bind udp_port_packet_reflector uppr_checker u_uppr_checker (.*);
